// ----- hw/rtl/adaptive_cad_threshold_controller_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the threshold controller
// Implication and next-cycle checks, clocked on clk, quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_CAD_THRESHOLD_CONTROLLER_ASSERT_SVH
`define ADAPTIVE_CAD_THRESHOLD_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ACTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ACTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ACTC_ASSERT_IMP(lbl, ante, cons, msg)
`define ACTC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/actc_pkg.sv -----
// ----------------------------------------------------------------------------
// actc_pkg
// Shared types, command codes and constants of the threshold controller.
// ----------------------------------------------------------------------------
package actc_pkg;

  localparam int DEF_NUM_LEVELS         = 16;
  localparam int LEVEL_MIN              = -8;
  localparam int STEP_MIN_PROBES        = 32;
  localparam int KNEE_SLOPE_PERMILLE    = 50;
  localparam int PLATEAU_CLEAN_PERMILLE = 50;
  localparam int PATHOLOGICAL_PERMILLE  = 900;
  localparam int SAFETY_MIN_PROBES      = 8;
  localparam int SAT_LIMIT              = 16'hFFF0;
  localparam int RATE_SCALE             = 1000;

  // dividend of a rate: 16-bit count times 1000
  localparam int DVD_W = 26;

  typedef logic signed [7:0]       off_t;
  typedef logic signed [11:0]      wide_t;
  typedef logic [15:0]             cnt_t;
  typedef logic [DVD_W-1:0]        dvd_t;
  typedef logic signed [DVD_W:0]   rate_t;
  typedef logic signed [DVD_W+1:0] rdiff_t;

  typedef struct packed {
    cnt_t probe;
    cnt_t busy;
    cnt_t fp;
    cnt_t tp;
  } entry_t;

  localparam logic [3:0] CMD_CFG   = 4'd0;
  localparam logic [3:0] CMD_PICK  = 4'd1;
  localparam logic [3:0] CMD_REC   = 4'd2;
  localparam logic [3:0] CMD_RES   = 4'd3;
  localparam logic [3:0] CMD_STAIR = 4'd4;
  localparam logic [3:0] CMD_SAFE  = 4'd5;
  localparam logic [3:0] CMD_RELAX = 4'd6;
  localparam logic [3:0] CMD_VBEG  = 4'd7;
  localparam logic [3:0] CMD_VEND  = 4'd8;
  localparam logic [3:0] CMD_CLR   = 4'd9;

  localparam logic [2:0] REG_AUTO  = 3'd0;
  localparam logic [2:0] REG_CAP   = 3'd1;
  localparam logic [2:0] REG_BASE  = 3'd2;
  localparam logic [2:0] REG_PMIN  = 3'd3;
  localparam logic [2:0] REG_PMAX  = 3'd4;
  localparam logic [2:0] REG_SOFF  = 3'd5;
  localparam logic [2:0] REG_SBASE = 3'd6;

  localparam logic [1:0] OUTC_TP = 2'd1;
  localparam logic [1:0] OUTC_FP = 2'd2;

  localparam logic [2:0] AS_LEVEL = 3'd0;
  localparam logic [2:0] AS_OP    = 3'd1;
  localparam logic [2:0] AS_UP    = 3'd2;
  localparam logic [2:0] AS_DN    = 3'd3;
  localparam logic [2:0] AS_SWEEP = 3'd4;

  localparam logic [1:0] WK_HALF = 2'd0;
  localparam logic [1:0] WK_REC  = 2'd1;
  localparam logic [1:0] WK_RES  = 2'd2;

  localparam logic [1:0] SLOT_OP  = 2'd0;
  localparam logic [1:0] SLOT_UP  = 2'd1;
  localparam logic [1:0] SLOT_DN  = 2'd2;
  localparam logic [1:0] SLOT_BDN = 2'd3;

  typedef struct packed {
    logic       take;
    logic       cfg_apply;
    logic       pick;
    logic       relax;
    logic       visit_begin;
    logic       visit_end;
    logic       clear;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_kind;
    logic       sweep_clr;
    logic       sweep_inc;
    logic       mul;
    logic       num_busy;
    logic       div_start;
    logic       rate_store;
    logic [1:0] slot;
    logic       stair_dec;
    logic       safe_dec;
    logic       finish;
  } actc_ctl_t;

  typedef struct packed {
    logic lvl_ok;
    logic op_ok;
    logic safe_ok;
    logic sat;
    logic sweep_last;
    logic div_done;
  } actc_stat_t;

endpackage

// ----- hw/rtl/actc_divider.sv -----
// ----------------------------------------------------------------------------
// actc_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module actc_divider (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  actc_pkg::dvd_t dividend,
  input  actc_pkg::cnt_t divisor,
  output actc_pkg::dvd_t quotient,
  output logic          done
);
  import actc_pkg::*;

  localparam int CW = $clog2(DVD_W);

  dvd_t          quo_r;
  cnt_t          rem_r;
  cnt_t          dvs_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  logic [16:0] rem_sh;
  logic [16:0] trial;
  logic        qbit;
  cnt_t        rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    trial   = rem_sh - {1'b0, dvs_r};
    qbit    = !trial[16];
    rem_nxt = qbit ? trial[15:0] : rem_sh[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[DVD_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ----- hw/rtl/actc_datapath.sv -----
// ----------------------------------------------------------------------------
// actc_datapath
// Offsets, configuration, per-level counter memory, rate arithmetic.
// ----------------------------------------------------------------------------
module actc_datapath #(
  parameter int NUM_LEVELS = actc_pkg::DEF_NUM_LEVELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  actc_pkg::actc_ctl_t   ctl,
  output actc_pkg::actc_stat_t  st,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [7:0]            cfg_wdata,
  input  logic signed [7:0]     in_level,
  input  logic                  in_busy_req,
  input  logic [1:0]            in_outcome,
  input  logic                  in_new_preset,
  output logic                  out_valid,
  output logic signed [7:0]     out_probe_level,
  output logic signed [7:0]     out_effective_offset,
  output logic                  out_stepped
);
  import actc_pkg::*;

  localparam int LW        = $clog2(NUM_LEVELS);
  localparam int LEVEL_MAX = LEVEL_MIN + NUM_LEVELS - 1;

  function automatic wide_t sat8(wide_t v);
    wide_t r;
    r = v;
    if (v < -wide_t'(128)) r = -wide_t'(128);
    if (v > wide_t'(127))  r = wide_t'(127);
    return r;
  endfunction

  function automatic logic idx_ok(wide_t v);
    return (v >= wide_t'(0)) && (v < wide_t'(NUM_LEVELS));
  endfunction

  function automatic wide_t zx8(logic [7:0] v);
    return wide_t'({4'b0000, v});
  endfunction

  // configuration registers
  logic       auto_en_r;
  logic [6:0] cap_pct_r;
  logic [7:0] base_r, pmin_r, pmax_r, sbase_r;
  off_t       soff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_en_r <= 1'b0;
      cap_pct_r <= '0;
      base_r    <= '0;
      pmin_r    <= '0;
      pmax_r    <= '0;
      soff_r    <= '0;
      sbase_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AUTO:  auto_en_r <= cfg_wdata[0];
        REG_CAP:   cap_pct_r <= cfg_wdata[6:0];
        REG_BASE:  base_r    <= cfg_wdata;
        REG_PMIN:  pmin_r    <= cfg_wdata;
        REG_PMAX:  pmax_r    <= cfg_wdata;
        REG_SOFF:  soff_r    <= cfg_wdata;
        REG_SBASE: sbase_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // offsets and latched controls
  off_t       op_r, vis_r, probe_r;
  logic       visiting_r, auto_lat_r, stepped_r;
  logic [6:0] cap_lat_r;
  logic [7:0] round_r;
  // probe round modulo the level count, kept alongside the round counter
  logic [LW-1:0] res_r, res_inc;

  off_t       lvl_r;
  logic       busyq_r, fresh_r;
  logic [1:0] outc_r;

  wide_t lmin_w, lmax_w, base_w, op_w, vis_w, lo_w, hi_w;
  wide_t oi, li, cfg_off, cand, pick_lvl, pick_mod_lvl;
  logic [7:0] round_inc;
  logic pick_div;

  // divider hookup
  dvd_t div_quot;
  logic div_done;
  dvd_t div_dvd;
  cnt_t div_dvs;

  always_comb begin
    lmin_w = wide_t'(LEVEL_MIN);
    lmax_w = wide_t'(LEVEL_MAX);
    base_w = zx8(base_r);
    op_w   = wide_t'(op_r);
    vis_w  = wide_t'(vis_r);

    lo_w = lmin_w;
    if (base_r != '0 && pmin_r != '0 && (base_w + lmin_w < zx8(pmin_r)))
      lo_w = sat8(zx8(pmin_r) - base_w);
    hi_w = lmax_w;
    if (base_r != '0 && pmax_r != '0 && (zx8(pmax_r) - base_w < lmax_w))
      hi_w = sat8(zx8(pmax_r) - base_w);

    // re-anchor the stored offset, then clamp; hi wins on an inverted window
    cfg_off = wide_t'(soff_r);
    if (sbase_r != '0 && base_r != '0 && sbase_r != base_r)
      cfg_off = sat8(cfg_off + zx8(sbase_r) - base_w);
    if (cfg_off < lo_w) cfg_off = lo_w;
    if (cfg_off > hi_w) cfg_off = hi_w;

    oi = op_w - lmin_w;
    li = wide_t'(lvl_r) - lmin_w;

    round_inc = round_r + 8'd1;
    // wrap the residue at the level count, and with the round counter
    res_inc = res_r + LW'(1);
    if (res_r == LW'(NUM_LEVELS - 1) || round_inc == 8'd0) res_inc = '0;
    case (round_inc[1:0])
      2'd1:    cand = op_w - wide_t'(1);
      2'd3:    cand = op_w + wide_t'(1);
      default: cand = op_w;
    endcase
    if (cand < lo_w || cand > hi_w) cand = op_w;
    pick_div = !auto_lat_r && op_w >= lmin_w && op_w <= lmax_w;
    pick_lvl = auto_lat_r ? cand : op_w;
    pick_mod_lvl = lmin_w + wide_t'({1'b0, res_inc});
  end

  // counter memory with per-entry valid bits; an invalid entry reads as zero
  entry_t            mem [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] vld_r;
  entry_t            rdq_r;
  logic              rdv_r, rd_ok_r;
  logic [LW-1:0]     sw_r;

  wide_t         rd_idx;
  logic [LW-1:0] rd_addr, wr_addr;
  logic          rd_ok;
  entry_t        ent, wr_data;

  always_comb begin
    case (ctl.rd_sel)
      AS_LEVEL: rd_idx = li;
      AS_OP:    rd_idx = oi;
      AS_UP:    rd_idx = oi + wide_t'(1);
      AS_DN:    rd_idx = oi - wide_t'(1);
      default:  rd_idx = wide_t'({1'b0, sw_r});
    endcase
    rd_addr = rd_idx[LW-1:0];
    rd_ok   = idx_ok(rd_idx);
    ent     = rdv_r ? rdq_r : '0;
    wr_addr = (ctl.wr_kind == WK_HALF) ? sw_r : li[LW-1:0];

    wr_data = ent;
    case (ctl.wr_kind)
      WK_HALF: begin
        wr_data.probe = ent.probe >> 1;
        wr_data.busy  = ent.busy >> 1;
        wr_data.fp    = ent.fp >> 1;
        wr_data.tp    = ent.tp >> 1;
      end
      WK_REC: begin
        wr_data.probe = ent.probe + cnt_t'(1);
        wr_data.busy  = ent.busy + cnt_t'(busyq_r);
      end
      default: begin
        if (outc_r == OUTC_TP) begin
          if (ent.tp != '1) wr_data.tp = ent.tp + cnt_t'(1);
        end else if (outc_r == OUTC_FP) begin
          if (ent.fp != '1) wr_data.fp = ent.fp + cnt_t'(1);
        end else begin
          if (ent.probe != '0) wr_data.probe = ent.probe - cnt_t'(1);
          if (ent.busy != '0)  wr_data.busy  = ent.busy - cnt_t'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) rdq_r <= mem[rd_addr];
    if (ctl.wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rdv_r   <= 1'b0;
      rd_ok_r <= 1'b0;
      sw_r    <= '0;
    end else begin
      if (ctl.rd_en) begin
        rdv_r   <= rd_ok && vld_r[rd_addr];
        rd_ok_r <= rd_ok;
      end
      if (ctl.clear)
        vld_r <= '0;
      else if (ctl.wr_en)
        vld_r[wr_addr] <= 1'b1;
      if (ctl.sweep_clr)
        sw_r <= '0;
      else if (ctl.sweep_inc)
        sw_r <= sw_r + LW'(1);
    end
  end

  // rate: count times 1000, registered, then divided by the probe count
  dvd_t  prod_r;
  cnt_t  dvs_r, nprb_r;
  logic  slot_ok_r;
  rate_t r_op_r, r_up_r, r_dn_r, b_dn_r;
  dvd_t  bop_r;
  cnt_t  num;

  always_comb begin
    num     = ctl.num_busy ? ent.busy : ent.fp;
    div_dvd = prod_r;
    div_dvs = dvs_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r    <= dvd_t'(num) * dvd_t'(RATE_SCALE);
      dvs_r     <= ent.probe;
      nprb_r    <= ent.probe;
      slot_ok_r <= rd_ok_r && ent.probe >= cnt_t'(STEP_MIN_PROBES);
    end
    if (ctl.rate_store) begin
      bop_r <= div_quot;
      case (ctl.slot)
        SLOT_OP: r_op_r <= slot_ok_r ? $signed({1'b0, div_quot}) : -rate_t'(1);
        SLOT_UP: r_up_r <= slot_ok_r ? $signed({1'b0, div_quot}) : -rate_t'(1);
        SLOT_DN: r_dn_r <= slot_ok_r ? $signed({1'b0, div_quot}) : -rate_t'(1);
        default: b_dn_r <= slot_ok_r ? $signed({1'b0, div_quot}) : -rate_t'(1);
      endcase
    end
  end

  actc_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctl.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .quotient  (div_quot),
    .done      (div_done)
  );

  // step decisions
  rdiff_t d_up, d_dn;
  rate_t  busy_lim;
  dvd_t   cap10;
  logic   stair_ok, up_mv, dn_mv, busy_ok, path, over, safe_mv, relax_mv;

  always_comb begin
    d_up     = rdiff_t'(r_op_r) - rdiff_t'(r_up_r);
    d_dn     = rdiff_t'(r_dn_r) - rdiff_t'(r_op_r);
    // cap - cap/5 with cap = 10 * pct is exactly 8 * pct
    busy_lim = $signed({{(DVD_W - 9){1'b0}}, cap_lat_r, 3'b000});
    busy_ok  = (cap_lat_r == '0) || (b_dn_r <= busy_lim);
    stair_ok = r_op_r >= rate_t'(0);
    up_mv    = op_w < hi_w && r_up_r >= rate_t'(0) &&
               d_up >= rdiff_t'(KNEE_SLOPE_PERMILLE);
    dn_mv    = op_w > lo_w && r_dn_r >= rate_t'(0) &&
               d_dn < rdiff_t'(KNEE_SLOPE_PERMILLE) &&
               r_op_r <= rate_t'(PLATEAU_CLEAN_PERMILLE) && busy_ok;
    cap10    = dvd_t'({cap_lat_r, 3'b000}) + dvd_t'({cap_lat_r, 1'b0});
    path     = nprb_r >= cnt_t'(SAFETY_MIN_PROBES) &&
               bop_r >= dvd_t'(PATHOLOGICAL_PERMILLE);
    over     = cap_lat_r != '0 && nprb_r >= cnt_t'(STEP_MIN_PROBES) && bop_r > cap10;
    safe_mv  = path || over;
    relax_mv = visiting_r ? (vis_w < hi_w) : (op_w < hi_w);
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      lvl_r   <= in_level;
      busyq_r <= in_busy_req;
      outc_r  <= in_outcome;
      fresh_r <= in_new_preset;
    end
  end

  logic out_valid_r, out_stepped_r;
  off_t out_probe_r, out_eff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= '0;
      vis_r       <= '0;
      visiting_r  <= 1'b0;
      round_r     <= '0;
      res_r       <= '0;
      auto_lat_r  <= 1'b0;
      cap_lat_r   <= '0;
      stepped_r   <= 1'b0;
      probe_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.finish;
      if (ctl.take) begin
        stepped_r <= 1'b0;
        probe_r   <= '0;
      end
      if (ctl.cfg_apply) begin
        op_r       <= cfg_off[7:0];
        auto_lat_r <= auto_en_r;
        cap_lat_r  <= cap_pct_r;
      end
      if (ctl.pick) begin
        round_r <= round_inc;
        res_r   <= res_inc;
        probe_r <= pick_div ? pick_mod_lvl[7:0] : pick_lvl[7:0];
      end
      if (ctl.relax && relax_mv) begin
        if (visiting_r) vis_r <= vis_r + off_t'(1);
        else            op_r  <= op_r + off_t'(1);
        stepped_r <= 1'b1;
      end
      if (ctl.stair_dec && stair_ok) begin
        if (up_mv) begin
          op_r      <= op_r + off_t'(1);
          stepped_r <= 1'b1;
        end else if (dn_mv) begin
          op_r      <= op_r - off_t'(1);
          stepped_r <= 1'b1;
        end
      end
      if (ctl.safe_dec && safe_mv) begin
        op_r      <= op_r + off_t'(1);
        stepped_r <= 1'b1;
      end
      if (ctl.visit_begin) begin
        vis_r      <= fresh_r ? off_t'(0) : op_r;
        visiting_r <= 1'b1;
      end
      if (ctl.visit_end) visiting_r <= 1'b0;
      if (ctl.clear) begin
        round_r <= '0;
        res_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_probe_r   <= probe_r;
      out_eff_r     <= visiting_r ? vis_r : op_r;
      out_stepped_r <= stepped_r;
    end
  end

  always_comb begin
    st.lvl_ok     = idx_ok(li);
    st.op_ok      = idx_ok(oi);
    st.safe_ok    = idx_ok(oi) && op_w < hi_w;
    st.sat        = ent.probe >= cnt_t'(SAT_LIMIT);
    st.sweep_last = sw_r == LW'(NUM_LEVELS - 1);
    st.div_done   = div_done;
  end

  assign out_valid            = out_valid_r;
  assign out_probe_level      = out_probe_r;
  assign out_effective_offset = out_eff_r;
  assign out_stepped          = out_stepped_r;

endmodule

// ----- hw/rtl/actc_controller.sv -----
// ----------------------------------------------------------------------------
// actc_controller
// Command sequencer: memory reads and writes, rate divisions, decisions.
// ----------------------------------------------------------------------------
module actc_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [3:0]           cmd,
  input  actc_pkg::actc_stat_t st,
  output actc_pkg::actc_ctl_t  ctl,
  output logic                 busy
);
  import actc_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_EXEC      = 4'd1;
  localparam logic [3:0] S_REC_RD    = 4'd3;
  localparam logic [3:0] S_REC_CHK   = 4'd4;
  localparam logic [3:0] S_HALF_RD   = 4'd5;
  localparam logic [3:0] S_HALF_WR   = 4'd6;
  localparam logic [3:0] S_RES_WR    = 4'd7;
  localparam logic [3:0] S_RT_RD     = 4'd8;
  localparam logic [3:0] S_RT_MUL    = 4'd9;
  localparam logic [3:0] S_RT_GO     = 4'd10;
  localparam logic [3:0] S_RT_DIV    = 4'd11;
  localparam logic [3:0] S_STAIR_DEC = 4'd12;
  localparam logic [3:0] S_SAFE_DEC  = 4'd13;
  localparam logic [3:0] S_DONE      = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [3:0] cmd_r, cmd_nxt;
  logic [1:0] slot_r, slot_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    slot_nxt  = slot_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.take  = 1'b1;
          cmd_nxt   = cmd;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (cmd_r)
          CMD_CFG:   ctl.cfg_apply = 1'b1;
          CMD_PICK:  ctl.pick      = 1'b1;
          CMD_REC: begin
            if (st.lvl_ok) begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = AS_LEVEL;
              state_nxt  = S_REC_CHK;
            end
          end
          CMD_RES: begin
            if (st.lvl_ok) begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = AS_LEVEL;
              state_nxt  = S_RES_WR;
            end
          end
          CMD_STAIR: begin
            if (st.op_ok) begin
              slot_nxt  = SLOT_OP;
              state_nxt = S_RT_RD;
            end
          end
          CMD_SAFE: begin
            if (st.safe_ok) begin
              slot_nxt  = SLOT_OP;
              state_nxt = S_RT_RD;
            end
          end
          CMD_RELAX: ctl.relax       = 1'b1;
          CMD_VBEG:  ctl.visit_begin = 1'b1;
          CMD_VEND:  ctl.visit_end   = 1'b1;
          CMD_CLR:   ctl.clear       = 1'b1;
          default: ;
        endcase
      end
      S_REC_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = AS_LEVEL;
        state_nxt  = S_REC_CHK;
      end
      S_REC_CHK: begin
        if (st.sat) begin
          // halve every level before counting this probe
          ctl.sweep_clr = 1'b1;
          state_nxt     = S_HALF_RD;
        end else begin
          ctl.wr_en   = 1'b1;
          ctl.wr_kind = WK_REC;
          state_nxt   = S_DONE;
        end
      end
      S_HALF_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = AS_SWEEP;
        state_nxt  = S_HALF_WR;
      end
      S_HALF_WR: begin
        ctl.wr_en     = 1'b1;
        ctl.wr_kind   = WK_HALF;
        ctl.sweep_inc = 1'b1;
        state_nxt     = st.sweep_last ? S_REC_RD : S_HALF_RD;
      end
      S_RES_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_kind = WK_RES;
        state_nxt   = S_DONE;
      end
      S_RT_RD: begin
        ctl.rd_en = 1'b1;
        unique case (slot_r)
          SLOT_OP: ctl.rd_sel = AS_OP;
          SLOT_UP: ctl.rd_sel = AS_UP;
          default: ctl.rd_sel = AS_DN;
        endcase
        state_nxt = S_RT_MUL;
      end
      S_RT_MUL: begin
        ctl.mul      = 1'b1;
        ctl.num_busy = (slot_r == SLOT_BDN) || (cmd_r == CMD_SAFE);
        state_nxt    = S_RT_GO;
      end
      S_RT_GO: begin
        ctl.div_start = 1'b1;
        state_nxt     = S_RT_DIV;
      end
      S_RT_DIV: begin
        if (st.div_done) begin
          ctl.rate_store = 1'b1;
          ctl.slot       = slot_r;
          if (cmd_r == CMD_SAFE) begin
            state_nxt = S_SAFE_DEC;
          end else if (slot_r == SLOT_BDN) begin
            state_nxt = S_STAIR_DEC;
          end else begin
            slot_nxt  = slot_r + 2'd1;
            state_nxt = S_RT_RD;
          end
        end
      end
      S_STAIR_DEC: begin
        ctl.stair_dec = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SAFE_DEC: begin
        ctl.safe_dec = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        ctl.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= CMD_CFG;
      slot_r  <= SLOT_OP;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      slot_r  <= slot_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

// ----- hw/rtl/adaptive_cad_threshold_controller.sv -----
// ----------------------------------------------------------------------------
// adaptive_cad_threshold_controller
// Adapts the detection threshold offset from per-level probe statistics.
// ----------------------------------------------------------------------------
// Usage: raise start with in_cmd and its operands while busy is low; the
// command is taken on that edge and busy rises the next cycle. Exactly one
// result per command appears on out_probe_level, out_effective_offset and
// out_stepped for a single cycle, flagged by out_valid; the receiver takes
// it then and cannot hold it off. out_valid comes in the cycle busy falls,
// so a new command may start in that same cycle.
// Record and resolve read and then write the counter memory; record first
// halves the whole counter table when the read entry has saturated. Each
// rate takes one read of the counter memory, a registered multiply and a
// restoring division of the 26-bit dividend; a safety step needs one such
// rate and the staircase needs four. The sweep pick keeps its own round
// residue, so it needs no division.
// Configuration writes on cfg_we land at once; the level window uses them at
// once, the offset, auto enable and cap from the next configure command. Reset
// clears all counters (per-level valid bits), offsets and latched controls.
// ----------------------------------------------------------------------------
`include "adaptive_cad_threshold_controller_assert.svh"

module adaptive_cad_threshold_controller #(
  parameter int NUM_LEVELS = actc_pkg::DEF_NUM_LEVELS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [3:0]        in_cmd,
  input  logic signed [7:0] in_level,
  input  logic              in_busy_req,
  input  logic [1:0]        in_outcome,
  input  logic              in_new_preset,
  output logic              out_valid,
  output logic signed [7:0] out_probe_level,
  output logic signed [7:0] out_effective_offset,
  output logic              out_stepped,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);
  import actc_pkg::*;

  actc_ctl_t  ctl;
  actc_stat_t st;

  actc_controller u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (in_cmd),
    .st    (st),
    .ctl   (ctl),
    .busy  (busy)
  );

  actc_datapath #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctl                  (ctl),
    .st                   (st),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_level             (in_level),
    .in_busy_req          (in_busy_req),
    .in_outcome           (in_outcome),
    .in_new_preset        (in_new_preset),
    .out_valid            (out_valid),
    .out_probe_level      (out_probe_level),
    .out_effective_offset (out_effective_offset),
    .out_stepped          (out_stepped)
  );

  `ACTC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
  `ACTC_ASSERT_IMP(a_result_idle, out_valid, !busy, "result shown while a command is running")
  `ACTC_ASSERT_NXT(a_result_once, out_valid, !out_valid, "result repeated")
  `ACTC_ASSERT_IMP(a_step_no_probe, out_valid && out_stepped, out_probe_level == 8'sd0,
                   "step result carries a probe level")

endmodule
